@@ src/launch_apogee_median_detector_assert.svh @@
// assertion macros for the launch and apogee detector core
`ifndef LAUNCH_APOGEE_MEDIAN_DETECTOR_ASSERT_SVH
`define LAUNCH_APOGEE_MEDIAN_DETECTOR_ASSERT_SVH

// property checked on every rising edge of clk, off while arst_n is low
`define LAMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be true on a rising edge of clk
`define LAMD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ src/lamd_pkg.sv @@
// types and constants shared by the launch and apogee detector modules
`timescale 1ns / 1ps
`default_nettype none

package lamd_pkg;

	// samples per median group
	localparam int GROUP_SIZE = 5;
	localparam int IDX_W      = $clog2(GROUP_SIZE);

	// field widths
	localparam int ACCEL_W  = 16;
	localparam int PRESS_W  = 17;
	localparam int VAL_W    = 18;
	localparam int THR_W    = 17;
	localparam int LIMIT_W  = 4;
	localparam int RUN_W    = 4;
	localparam int PHASE_W  = 2;

	// stream and config port widths
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 17;

	// register indexes on the config port
	localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_THRESHOLD  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LAUNCH_RUN_LIMIT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_APOGEE_RUN_LIMIT = 2'd2;

	// register reset values
	localparam logic [THR_W-1:0]   ACCEL_THRESHOLD_RST  = 17'd6144;
	localparam logic [LIMIT_W-1:0] LAUNCH_RUN_LIMIT_RST = 4'd5;
	localparam logic [LIMIT_W-1:0] APOGEE_RUN_LIMIT_RST = 4'd5;

	// run counter saturates here
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_LAUNCH      = 2'd0,
		PH_APOGEE_WAIT = 2'd1,
		PH_DONE        = 2'd2
	} phase_t;

	// one input transaction
	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_x;
		logic signed [ACCEL_W-1:0] accel_y;
		logic signed [ACCEL_W-1:0] accel_z;
		logic [PRESS_W-1:0]        pressure_pa;
	} sample_t;

	// one output transaction
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               launch_event;
		logic               apogee_event;
		logic               group_done;
		val_t               group_median;
		logic [RUN_W-1:0]   run_length;
	} result_t;

endpackage

`default_nettype wire

@@ src/lamd_median.sv @@
// median of one group of values by an odd-even transposition network
`timescale 1ns / 1ps
`default_nettype none

module lamd_median (
	input  wire lamd_pkg::val_t [lamd_pkg::GROUP_SIZE-1:0] win,
	output lamd_pkg::val_t                                 median
);
	import lamd_pkg::*;

	val_t srt [GROUP_SIZE];

	// compare-exchange rounds, alternating even and odd pairs
	always_comb begin
		val_t tmp;
		tmp = '0;
		for (int i = 0; i < GROUP_SIZE; i++) begin
			srt[i] = win[i];
		end
		for (int r = 0; r < GROUP_SIZE; r++) begin
			for (int j = r % 2; j + 1 < GROUP_SIZE; j += 2) begin
				if (srt[j] > srt[j+1]) begin
					tmp      = srt[j];
					srt[j]   = srt[j+1];
					srt[j+1] = tmp;
				end
			end
		end
	end

	assign median = srt[GROUP_SIZE/2];

endmodule

`default_nettype wire

@@ src/lamd_core.sv @@
// group buffer, phase and run tracking, and config registers of the detector
`timescale 1ns / 1ps
`default_nettype none
`include "launch_apogee_median_detector_assert.svh"

module lamd_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [lamd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire  [lamd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire                                 step,
	input  wire  lamd_pkg::sample_t             sample,
	output lamd_pkg::result_t                   res
);
	import lamd_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SIZE - 1);

	// config registers
	logic [THR_W-1:0]   accel_threshold_q;
	logic [LIMIT_W-1:0] launch_run_limit_q;
	logic [LIMIT_W-1:0] apogee_run_limit_q;

	// detector state
	phase_t             phase_q, phase_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [RUN_W-1:0]   run_q, run_d;
	logic [PRESS_W-1:0] prev_q, prev_d;
	logic               pv_q, pv_d;
	val_t               buf_q [GROUP_SIZE];

	val_t                        value;
	val_t [GROUP_SIZE-1:0]       win;
	val_t                        med;
	logic                        active;
	logic                        last;
	logic [RUN_W-1:0]            run_inc;
	logic                        launch_ev;
	logic                        apogee_ev;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_threshold_q  <= ACCEL_THRESHOLD_RST;
			launch_run_limit_q <= LAUNCH_RUN_LIMIT_RST;
			apogee_run_limit_q <= APOGEE_RUN_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ACCEL_THRESHOLD:  accel_threshold_q  <= cfg_wdata[THR_W-1:0];
				REG_LAUNCH_RUN_LIMIT: launch_run_limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_APOGEE_RUN_LIMIT: apogee_run_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// value taken from the sample depends on phase
	always_comb begin
		if (phase_q == PH_LAUNCH) begin
			value = val_t'(sample.accel_x) + val_t'(sample.accel_y) + val_t'(sample.accel_z);
		end else begin
			value = val_t'({1'b0, sample.pressure_pa});
		end
	end

	// window is the stored group with the new value in its slot
	always_comb begin
		for (int i = 0; i < GROUP_SIZE; i++) begin
			win[i] = (idx_q == IDX_W'(i)) ? value : buf_q[i];
		end
	end

	lamd_median u_median (
		.win    (win),
		.median (med)
	);

	assign active  = (phase_q != PH_DONE);
	assign last    = (idx_q == LAST_IDX);
	assign run_inc = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);

	// next state and result for the sample in flight
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		run_d     = run_q;
		prev_d    = prev_q;
		pv_d      = pv_q;
		launch_ev = 1'b0;
		apogee_ev = 1'b0;
		if (active) begin
			idx_d = last ? '0 : idx_q + IDX_W'(1);
			if (last) begin
				if (phase_q == PH_LAUNCH) begin
					if (med > val_t'({1'b0, accel_threshold_q})) begin
						run_d = run_inc;
						if (run_inc >= launch_run_limit_q) begin
							launch_ev = 1'b1;
							phase_d   = PH_APOGEE_WAIT;
							run_d     = '0;
							pv_d      = 1'b0;
						end
					end else begin
						run_d = '0;
					end
				end else begin
					// first group after launch only seeds the previous median
					if (!pv_q) begin
						pv_d = 1'b1;
					end else if (med > val_t'({1'b0, prev_q})) begin
						run_d = run_inc;
						if (run_inc >= apogee_run_limit_q) begin
							apogee_ev = 1'b1;
							phase_d   = PH_DONE;
						end
					end else begin
						run_d = '0;
					end
					prev_d = med[PRESS_W-1:0];
				end
			end
		end
		res.phase        = phase_d;
		res.launch_event = launch_ev;
		res.apogee_event = apogee_ev;
		res.group_done   = active && last;
		res.group_median = (active && last) ? med : '0;
		res.run_length   = run_d;
	end

	// state registers advance once per processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LAUNCH;
			idx_q   <= '0;
			run_q   <= '0;
			prev_q  <= '0;
			pv_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			run_q   <= run_d;
			prev_q  <= prev_d;
			pv_q    <= pv_d;
		end
	end

	// group buffer, no reset
	always_ff @(posedge clk) begin
		if (step && active) begin
			buf_q[idx_q] <= value;
		end
	end

	`LAMD_NEVER(a_idx_range, idx_q > LAST_IDX, "group index past end of group")
	`LAMD_ASSERT(a_done_sticks, phase_q == PH_DONE |=> phase_q == PH_DONE, "left apogee phase")
	`LAMD_ASSERT(a_group_wraps, step && res.group_done |=> idx_q == '0, "group did not restart")
	`LAMD_ASSERT(a_launch_clears, step && res.launch_event |=> phase_q == PH_APOGEE_WAIT && run_q == '0 && !pv_q, "launch did not clear run state")

endmodule

`default_nettype wire

@@ src/launch_apogee_median_detector.sv @@
// Launch and apogee detector: median-of-five groups with run counting.
// Input stream s_axis carries one sensor sample per transaction: three raw
// accelerometer axes and a pressure reading. Output stream m_axis returns
// exactly one result per sample, in order: phase, launch and apogee events,
// group completion, the group median and the current run length.
// Config port: cfg_we with cfg_addr 0 threshold, 1 launch limit, 2 apogee
// limit; write only while no samples are in flight.
// Path: an accepted sample is registered in the input stage, and its result
// is registered in the result stage once that stage is free, which raises
// m_axis_tvalid. Throughput: one sample per cycle while m_axis_tready is
// high; the median network and the run update are combinational in between.
// Reset: arst_n clears both stream stages, selects launch phase, clears the
// run counter and group position, and loads the register defaults.
// Stall: while m_axis_tready is low the result holds, the input stage keeps
// one more sample, and s_axis_tready drops once that stage is full.
`timescale 1ns / 1ps
`default_nettype none

module launch_apogee_median_detector (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// accel_x[15:0] accel_y[31:16] accel_z[47:32] pressure_pa[64:48]
	input  wire  [lamd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// phase[1:0] launch_event[2] apogee_event[3] group_done[4]
	// group_median[22:5] run_length[26:23]
	output logic [lamd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	input  wire                                 cfg_we,
	input  wire  [lamd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire  [lamd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import lamd_pkg::*;

	sample_t sample_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res;
	logic    advance;

	// sample moves to the result stage when that stage is empty or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1.accel_x     <= s_axis_tdata[15:0];
			sample_s1.accel_y     <= s_axis_tdata[31:16];
			sample_s1.accel_z     <= s_axis_tdata[47:32];
			sample_s1.pressure_pa <= s_axis_tdata[64:48];
		end
	end

	lamd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.sample    (sample_s1),
		.res       (res)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'b0, res_s2.run_length, res_s2.group_median,
		res_s2.group_done, res_s2.apogee_event, res_s2.launch_event, res_s2.phase};

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the launch and apogee median detector
`timescale 1ns / 1ps

module tb;
	import lamd_pkg::*;

	localparam int SUM_MIN      = -98304;
	localparam int SUM_MAX      = 98301;
	localparam int PRESS_MAX    = 131071;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 80;
	// index past the end of the register map, writes must be dropped
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	// accel_x[15:0] accel_y[31:16] accel_z[47:32] pressure_pa[64:48]
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// phase[1:0] launch_event[2] apogee_event[3] group_done[4]
	// group_median[22:5] run_length[26:23]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

	// flight state as the detector should hold it
	phase_t             fl_phase;
	val_t               fl_window[GROUP_SIZE];
	int                 fl_fill;
	logic [RUN_W-1:0]   fl_run;
	val_t               fl_prev_median;
	bit                 fl_prev_valid;
	logic [THR_W-1:0]   thr_reg;
	logic [LIMIT_W-1:0] launch_lim_reg;
	logic [LIMIT_W-1:0] apogee_lim_reg;

	result_t pending_status[$];

	int fail_count   = 0;
	int sample_count = 0;
	int group_count  = 0;
	int launch_seen  = 0;
	int apogee_seen  = 0;
	int write_count  = 0;
	int burst_left   = 0;
	int idle_cycles  = 0;

	// receiver stall control
	bit       hold_request = 1'b0;
	int       hold_left    = 0;
	rx_mode_t rx_mode      = RX_ALWAYS;
	int       rx_mode_left = 0;
	int       rx_tick      = 0;

	launch_apogee_median_detector uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void bump_run();
		if (fl_run != RUN_MAX)
			fl_run = fl_run + 1'b1;
	endfunction

	// advance the flight state by one sample and return the status it should produce
	function automatic result_t next_flight_status(sample_t smp);
		result_t st;
		val_t    v;
		val_t    med;
		val_t    sorted[GROUP_SIZE];
		val_t    key;
		int      j;
		st  = '0;
		med = '0;
		if (fl_phase != PH_DONE) begin
			if (fl_phase == PH_LAUNCH)
				v = val_t'($signed(smp.accel_x)) + val_t'($signed(smp.accel_y))
					+ val_t'($signed(smp.accel_z));
			else
				v = val_t'({1'b0, smp.pressure_pa});
			fl_window[fl_fill] = v;
			fl_fill++;
			if (fl_fill == GROUP_SIZE) begin
				fl_fill = 0;
				st.group_done = 1'b1;
				// insertion sort, median sits in the middle slot
				sorted = fl_window;
				for (int i = 1; i < GROUP_SIZE; i++) begin
					key = sorted[i];
					j = i - 1;
					while (j >= 0 && sorted[j] > key) begin
						sorted[j + 1] = sorted[j];
						j--;
					end
					sorted[j + 1] = key;
				end
				med = sorted[GROUP_SIZE / 2];
				if (fl_phase == PH_LAUNCH) begin
					if (med > val_t'({1'b0, thr_reg})) begin
						bump_run();
						if (fl_run >= launch_lim_reg) begin
							st.launch_event = 1'b1;
							fl_phase = PH_APOGEE_WAIT;
							fl_run = '0;
							fl_prev_valid = 1'b0;
						end
					end else begin
						fl_run = '0;
					end
				end else begin
					// first apogee group only seeds the comparison
					if (!fl_prev_valid) begin
						fl_prev_valid = 1'b1;
					end else if (med > fl_prev_median) begin
						bump_run();
						if (fl_run >= apogee_lim_reg) begin
							st.apogee_event = 1'b1;
							fl_phase = PH_DONE;
						end
					end else begin
						fl_run = '0;
					end
					fl_prev_median = med;
				end
			end
		end
		st.phase        = fl_phase;
		st.group_median = med;
		st.run_length   = fl_run;
		return st;
	endfunction

	function automatic int rand_between(int lo, int hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	// axes split so that their sum is exactly total
	function automatic sample_t sample_of_sum(int total, int press);
		sample_t smp;
		int      base;
		int      part;
		int      spare;
		base  = total - SUM_MIN;
		part  = base / 3;
		spare = base - 3 * part;
		smp.accel_x     = 16'(part - 32768 + int'(spare > 0));
		smp.accel_y     = 16'(part - 32768 + int'(spare > 1));
		smp.accel_z     = 16'(part - 32768);
		smp.pressure_pa = 17'(press);
		return smp;
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		smp.accel_x     = 16'($urandom);
		smp.accel_y     = 16'($urandom);
		smp.accel_z     = 16'($urandom);
		smp.pressure_pa = 17'($urandom_range(0, PRESS_MAX));
		return smp;
	endfunction

	function automatic void check_field(string name, int expd, int got);
		if (expd != got) begin
			$error("%s: expected %0d, got %0d", name, expd, got);
			fail_count++;
		end
	endfunction

	// offer one sample in bursts with random gaps, record its expected status
	task automatic send_sample(sample_t smp);
		int      gap;
		result_t st;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tdata  <= {{(IN_TDATA_W - 3 * ACCEL_W - PRESS_W){1'b0}}, smp.pressure_pa,
			smp.accel_z, smp.accel_y, smp.accel_x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		st = next_flight_status(smp);
		pending_status.push_back(st);
		sample_count++;
		group_count += int'(st.group_done);
		launch_seen += int'(st.launch_event);
		apogee_seen += int'(st.apogee_event);
	endtask

	// shuffle a group and send it
	task automatic send_group(sample_t grp[GROUP_SIZE]);
		sample_t tmp;
		int      k;
		for (int i = GROUP_SIZE - 1; i > 0; i--) begin
			k = int'($urandom_range(0, i));
			tmp = grp[i];
			grp[i] = grp[k];
			grp[k] = tmp;
		end
		foreach (grp[i])
			send_sample(grp[i]);
	endtask

	// three sums on one side of the threshold fix the median, two are noise
	task automatic send_accel_group(bit above);
		sample_t grp[GROUP_SIZE];
		int      thr;
		thr = int'(thr_reg);
		foreach (grp[i]) begin
			if (i >= 3)
				grp[i] = random_sample();
			else if (above)
				grp[i] = sample_of_sum(rand_between(thr + 1, SUM_MAX),
					int'($urandom_range(0, PRESS_MAX)));
			else
				grp[i] = sample_of_sum(rand_between(SUM_MIN, thr),
					int'($urandom_range(0, PRESS_MAX)));
		end
		send_group(grp);
	endtask

	// pressure group whose median is med, flat or spread around it
	task automatic send_pressure_group(int med, bit spread);
		sample_t grp[GROUP_SIZE];
		int      p;
		foreach (grp[i]) begin
			if (!spread || i == 0)
				p = med;
			else if (i < 3)
				p = rand_between(0, med);
			else
				p = rand_between(med, PRESS_MAX);
			grp[i] = random_sample();
			grp[i].pressure_pa = 17'(p);
		end
		send_group(grp);
	endtask

	// stop offering and wait until every expected status has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_ACCEL_THRESHOLD:  thr_reg = data[THR_W-1:0];
			REG_LAUNCH_RUN_LIMIT: launch_lim_reg = data[LIMIT_W-1:0];
			REG_APOGEE_RUN_LIMIT: apogee_lim_reg = data[LIMIT_W-1:0];
			default: ;
		endcase
		write_count++;
	endtask

	// field extremes and threshold edges while awaiting launch
	task automatic test_launch_directed();
		sample_t grp[GROUP_SIZE];
		foreach (grp[i])
			grp[i] = sample_of_sum(SUM_MIN, 0);
		send_group(grp);
		foreach (grp[i])
			grp[i] = sample_of_sum(SUM_MAX, PRESS_MAX);
		send_group(grp);
		// threshold at the largest sum, so even the largest sum is not above it
		write_register(REG_ACCEL_THRESHOLD, CFG_DATA_W'(SUM_MAX));
		send_group(grp);
		// zero threshold, a median of exactly zero does not count
		write_register(REG_ACCEL_THRESHOLD, '0);
		write_register(REG_UNUSED, '1);
		foreach (grp[i])
			grp[i] = sample_of_sum(0, int'($urandom_range(0, PRESS_MAX)));
		grp[3] = sample_of_sum(1, int'($urandom_range(0, PRESS_MAX)));
		grp[4] = sample_of_sum(-1, int'($urandom_range(0, PRESS_MAX)));
		send_group(grp);
	endtask

	// runs above threshold that build up and break just short of launch
	task automatic test_launch_runs();
		bit above;
		int thr;
		int lim;
		for (int setting = 0; setting < 6; setting++) begin
			case (setting)
				0: thr = 0;
				1: thr = SUM_MAX - 1;
				5: thr = rand_between(0, SUM_MAX);
				default: thr = rand_between(0, 40000);
			endcase
			lim = (setting == 0) ? 15 : int'($urandom_range(8, 15));
			write_register(REG_ACCEL_THRESHOLD, CFG_DATA_W'(thr));
			write_register(REG_LAUNCH_RUN_LIMIT,
				{(CFG_DATA_W - LIMIT_W)'($urandom), LIMIT_W'(lim)});
			for (int g = 0; g < 12; g++) begin
				// long receiver hold-off while samples keep coming
				if (setting == 2 && g == 4)
					hold_request = 1'b1;
				above = ($urandom_range(0, 99) < 70) && (thr_reg < SUM_MAX)
					&& (int'(fl_run) + 1 < lim);
				send_accel_group(above);
			end
		end
	endtask

	// a limit of zero with junk above it fires on the first group over threshold
	task automatic test_launch_declare();
		write_register(REG_ACCEL_THRESHOLD, CFG_DATA_W'(4096));
		write_register(REG_LAUNCH_RUN_LIMIT,
			{(CFG_DATA_W - LIMIT_W)'($urandom), LIMIT_W'(0)});
		send_accel_group(1'b0);
		while (fl_phase == PH_LAUNCH)
			send_accel_group(1'b1);
	endtask

	// seeding group, equal, falling and rising medians at the pressure extremes
	task automatic test_apogee_seed();
		write_register(REG_APOGEE_RUN_LIMIT, CFG_DATA_W'(15));
		send_pressure_group(PRESS_MAX, 1'b0);
		send_pressure_group(PRESS_MAX, 1'b0);
		send_pressure_group(0, 1'b0);
		send_pressure_group(1, 1'b1);
	endtask

	// random walk of pressure medians, rising runs broken before apogee
	task automatic test_apogee_runs();
		int lim;
		int prev;
		int med;
		for (int setting = 0; setting < 5; setting++) begin
			lim = (setting == 0) ? 15 : int'($urandom_range(8, 15));
			write_register(REG_APOGEE_RUN_LIMIT,
				{(CFG_DATA_W - LIMIT_W)'($urandom), LIMIT_W'(lim)});
			for (int g = 0; g < 11; g++) begin
				// sender pause until the pipeline is empty
				if (setting == 3 && g == 5)
					wait_drained();
				prev = int'(fl_prev_median);
				if (($urandom_range(0, 99) < 70) && prev < PRESS_MAX
					&& int'(fl_run) + 1 < lim)
					med = prev + int'($urandom_range(1,
						(PRESS_MAX - prev < 6000) ? PRESS_MAX - prev : 6000));
				else if ($urandom_range(0, 3) == 0)
					med = prev;
				else
					med = rand_between(0, prev);
				send_pressure_group(med, 1'b1);
			end
		end
	endtask

	// fifteen rising medians in a row declare apogee at the largest limit
	task automatic test_apogee_declare();
		write_register(REG_APOGEE_RUN_LIMIT, CFG_DATA_W'(15));
		send_pressure_group(0, 1'b1);
		while (fl_phase != PH_DONE)
			send_pressure_group(int'(fl_prev_median) + int'($urandom_range(1, 6000)), 1'b1);
	endtask

	// once apogee is reached samples are ignored and the run count holds
	task automatic test_after_apogee();
		write_register(REG_ACCEL_THRESHOLD, CFG_DATA_W'($urandom));
		write_register(REG_LAUNCH_RUN_LIMIT, CFG_DATA_W'($urandom));
		write_register(REG_APOGEE_RUN_LIMIT, CFG_DATA_W'($urandom));
		repeat (40) send_sample(random_sample());
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_st;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_status.size() == 0) begin
				$error("result transaction with no sample outstanding");
				fail_count++;
			end else begin
				exp_st = pending_status.pop_front();
				check_field("phase", int'(exp_st.phase), int'(m_axis_tdata[1:0]));
				check_field("launch_event", int'(exp_st.launch_event), int'(m_axis_tdata[2]));
				check_field("apogee_event", int'(exp_st.apogee_event), int'(m_axis_tdata[3]));
				check_field("group_done", int'(exp_st.group_done), int'(m_axis_tdata[4]));
				check_field("group_median", int'(exp_st.group_median),
					int'($signed(m_axis_tdata[22:5])));
				check_field("run_length", int'(exp_st.run_length), int'(m_axis_tdata[26:23]));
			end
		end
	end

	// receiver: changing stall modes plus requested long hold-offs
	always @(posedge clk) begin
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 150);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= 1'($urandom);
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:   m_axis_tready <= (rx_tick % 7 != 3) && (rx_tick % 7 != 4);
			endcase
		end
	end

	// watchdog on cycles with no transaction on either stream
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		fl_phase       = PH_LAUNCH;
		fl_window      = '{default: '0};
		fl_fill        = 0;
		fl_run         = '0;
		fl_prev_median = '0;
		fl_prev_valid  = 1'b0;
		thr_reg        = ACCEL_THRESHOLD_RST;
		launch_lim_reg = LAUNCH_RUN_LIMIT_RST;
		apogee_lim_reg = APOGEE_RUN_LIMIT_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_launch_directed();
		test_launch_runs();
		test_launch_declare();
		test_apogee_seed();
		test_apogee_runs();
		test_apogee_declare();
		test_after_apogee();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d samples in %0d completed groups with %0d register writes",
			sample_count, group_count, write_count);
		$display("launch declared %0d time(s), apogee declared %0d time(s), %0d failure(s)",
			launch_seen, apogee_seen, fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
